// ===== design/inc_dec_button_pair_events_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the inc/dec button pair event unit
// Shared property forms, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INC_DEC_BUTTON_PAIR_EVENTS_UNIT_DEFINES_SVH
`define INC_DEC_BUTTON_PAIR_EVENTS_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define IDBPE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define IDBPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

// ===== design/idbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Inc/dec button pair event package
// Button state, press mode, event and register codes used by the unit.
// ----------------------------------------------------------------------------
package idbpe_pkg;

    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int BTN_W   = 2;
    localparam int MODE_W  = 2;
    localparam int EVENT_W = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    typedef logic [BTN_W-1:0]   t_btn;
    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [EVENT_W-1:0] t_event;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [DELAY_W-1:0] t_delay;

    // debounced button states
    localparam t_btn ST_PRESSED  = 2'd0;
    localparam t_btn ST_RELEASED = 2'd1;
    localparam t_btn ST_FALL     = 2'd2;
    localparam t_btn ST_RISE     = 2'd3;

    // long-press mode
    localparam t_mode MODE_INITIAL     = 2'd0;
    localparam t_mode MODE_LONG        = 2'd1;
    localparam t_mode MODE_AFTER_RESET = 2'd2;

    // event codes
    localparam t_event EV_NONE      = 3'd0;
    localparam t_event EV_INC_SHORT = 3'd1;
    localparam t_event EV_INC_LONG  = 3'd2;
    localparam t_event EV_INC_HOLD  = 3'd3;
    localparam t_event EV_DEC_SHORT = 3'd4;
    localparam t_event EV_DEC_LONG  = 3'd5;
    localparam t_event EV_DEC_HOLD  = 3'd6;
    localparam t_event EV_RESET     = 3'd7;

    // register index, taken from address bit 2
    localparam logic REG_LONG_DELAY   = 1'b0;
    localparam logic REG_REPEAT_DELAY = 1'b1;

    localparam t_delay LONG_DELAY_RST   = 16'd450;
    localparam t_delay REPEAT_DELAY_RST = 16'd200;

endpackage

// ===== design/inc_dec_button_pair_events_unit.sv =====
// ----------------------------------------------------------------------------
// Inc/dec button pair event unit
// Turns each poll tick of two debounced buttons into one event code.
// ----------------------------------------------------------------------------
// Datapath: input register, then decision logic into the result register.
// Throughput: 1 item per cycle while the result channel is not stalled; the press
//   mode and repeat stamp update in the same cycle that the decision is made.
// Reset (synchronous, active low): press mode initial, repeat stamp zero,
//   delays 450 ms and 200 ms, both pipeline stages empty.
`include "inc_dec_button_pair_events_unit_defines.svh"

module inc_dec_button_pair_events_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [idbpe_pkg::BTN_W-1:0]      i_incr_state,
    input  logic [idbpe_pkg::BTN_W-1:0]      i_decr_state,
    input  logic [idbpe_pkg::TIME_W-1:0]     i_incr_stable_ms,
    input  logic [idbpe_pkg::TIME_W-1:0]     i_decr_stable_ms,
    input  logic [idbpe_pkg::TIME_W-1:0]     i_now_ms,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [idbpe_pkg::EVENT_W-1:0]    o_event_res,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [idbpe_pkg::ADDR_W-1:0]     paddr,
    input  logic [idbpe_pkg::DATA_W-1:0]     pwdata,
    output logic [idbpe_pkg::DATA_W-1:0]     prdata,
    output logic                             pready
);

    // configuration registers
    idbpe_pkg::t_delay r_long_delay;
    idbpe_pkg::t_delay r_repeat_delay;

    // input stage
    logic                r_in_valid;
    idbpe_pkg::t_btn     r_incr_state;
    idbpe_pkg::t_btn     r_decr_state;
    idbpe_pkg::t_time    r_incr_stable;
    idbpe_pkg::t_time    r_decr_stable;
    idbpe_pkg::t_time    r_now;

    // block state
    idbpe_pkg::t_mode    r_mode;
    idbpe_pkg::t_time    r_stamp;

    // result stage
    logic                r_out_valid;
    idbpe_pkg::t_event   r_event;

    idbpe_pkg::t_mode    n_mode;
    idbpe_pkg::t_time    n_stamp;
    idbpe_pkg::t_event   n_event;

    logic                adv;
    logic                fire;
    logic                in_accept;
    logic                cfg_wr;

    logic                inc_rel;
    logic                dec_rel;
    logic                sel_inc;
    idbpe_pkg::t_time    sel_stable;
    idbpe_pkg::t_time    since_stamp;
    logic                hold_due;
    logic                long_due;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign adv        = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == idbpe_pkg::REG_LONG_DELAY) begin
            prdata[idbpe_pkg::DELAY_W-1:0] = r_long_delay;
        end else begin
            prdata[idbpe_pkg::DELAY_W-1:0] = r_repeat_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_delay   <= idbpe_pkg::LONG_DELAY_RST;
            r_repeat_delay <= idbpe_pkg::REPEAT_DELAY_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == idbpe_pkg::REG_LONG_DELAY) begin
                r_long_delay <= pwdata[idbpe_pkg::DELAY_W-1:0];
            end else begin
                r_repeat_delay <= pwdata[idbpe_pkg::DELAY_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_incr_state  <= i_incr_state;
            r_decr_state  <= i_decr_state;
            r_incr_stable <= i_incr_stable_ms;
            r_decr_stable <= i_decr_stable_ms;
            r_now         <= i_now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Decision logic
    // ------------------------------------------------------------------
    // released or on a release edge
    assign inc_rel = (r_incr_state == idbpe_pkg::ST_RELEASED) ||
                     (r_incr_state == idbpe_pkg::ST_RISE);
    assign dec_rel = (r_decr_state == idbpe_pkg::ST_RELEASED) ||
                     (r_decr_state == idbpe_pkg::ST_RISE);

    // long-press path follows the increment button when it is pressed, else the decrement button
    assign sel_inc     = (r_incr_state == idbpe_pkg::ST_PRESSED);
    assign sel_stable  = sel_inc ? r_incr_stable : r_decr_stable;
    assign since_stamp = r_now - r_stamp;
    assign hold_due    = since_stamp >= {{(idbpe_pkg::TIME_W-idbpe_pkg::DELAY_W){1'b0}},
                                         r_repeat_delay};
    assign long_due    = sel_stable >= {{(idbpe_pkg::TIME_W-idbpe_pkg::DELAY_W){1'b0}},
                                        r_long_delay};

    always_comb begin
        n_event = idbpe_pkg::EV_NONE;
        n_mode  = r_mode;
        n_stamp = r_stamp;
        priority if (r_incr_state == idbpe_pkg::ST_RELEASED &&
                     r_decr_state == idbpe_pkg::ST_RELEASED) begin
            n_event = idbpe_pkg::EV_NONE;
        end else if (inc_rel && dec_rel) begin
            // last button let go: rearm long press
            n_mode = idbpe_pkg::MODE_INITIAL;
        end else if (r_incr_state == idbpe_pkg::ST_FALL &&
                     r_decr_state == idbpe_pkg::ST_FALL) begin
            n_event = idbpe_pkg::EV_RESET;
            n_mode  = idbpe_pkg::MODE_AFTER_RESET;
        end else if (r_incr_state == idbpe_pkg::ST_FALL) begin
            if (r_decr_state == idbpe_pkg::ST_PRESSED) begin
                n_event = idbpe_pkg::EV_RESET;
                n_mode  = idbpe_pkg::MODE_AFTER_RESET;
            end else begin
                n_event = idbpe_pkg::EV_INC_SHORT;
            end
        end else if (r_decr_state == idbpe_pkg::ST_FALL) begin
            if (r_incr_state == idbpe_pkg::ST_PRESSED) begin
                n_event = idbpe_pkg::EV_RESET;
                n_mode  = idbpe_pkg::MODE_AFTER_RESET;
            end else begin
                n_event = idbpe_pkg::EV_DEC_SHORT;
            end
        end else if (r_incr_state == idbpe_pkg::ST_PRESSED &&
                     r_decr_state == idbpe_pkg::ST_PRESSED) begin
            n_event = idbpe_pkg::EV_NONE;
        end else if (r_mode != idbpe_pkg::MODE_AFTER_RESET &&
                     (r_incr_state == idbpe_pkg::ST_PRESSED ||
                      r_decr_state == idbpe_pkg::ST_PRESSED)) begin
            if (r_mode == idbpe_pkg::MODE_LONG) begin
                if (hold_due) begin
                    n_stamp = r_stamp + {{(idbpe_pkg::TIME_W-idbpe_pkg::DELAY_W){1'b0}},
                                         r_repeat_delay};
                    n_event = sel_inc ? idbpe_pkg::EV_INC_HOLD : idbpe_pkg::EV_DEC_HOLD;
                end
            end else if (long_due) begin
                n_mode  = idbpe_pkg::MODE_LONG;
                n_stamp = r_now;
                n_event = sel_inc ? idbpe_pkg::EV_INC_LONG : idbpe_pkg::EV_DEC_LONG;
            end
        end else begin
            n_event = idbpe_pkg::EV_NONE;
        end
    end

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= idbpe_pkg::MODE_INITIAL;
            r_stamp <= '0;
        end else if (fire) begin
            r_mode  <= n_mode;
            r_stamp <= n_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_event <= n_event;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IDBPE_ASSERT_NEXT(a_fire_gives_result, fire, r_out_valid)
    `IDBPE_ASSERT_NEXT(a_reset_sets_mode, fire && n_event == idbpe_pkg::EV_RESET,
        r_mode == idbpe_pkg::MODE_AFTER_RESET)
    `IDBPE_ASSERT_NEXT(a_long_takes_stamp,
        fire && (n_event == idbpe_pkg::EV_INC_LONG || n_event == idbpe_pkg::EV_DEC_LONG),
        r_stamp == $past(r_now) && r_mode == idbpe_pkg::MODE_LONG)
    `IDBPE_ASSERT_SAME(a_no_long_after_reset,
        r_in_valid && r_mode == idbpe_pkg::MODE_AFTER_RESET,
        n_event != idbpe_pkg::EV_INC_LONG && n_event != idbpe_pkg::EV_DEC_LONG &&
        n_event != idbpe_pkg::EV_INC_HOLD && n_event != idbpe_pkg::EV_DEC_HOLD)

endmodule
